// ===== sv/aetp_pkg.sv =====
// ----------------------------------------------------------------------------
// ANSI terminal parser package
// Shared types, codes and helper functions of the terminal stream parser.
// ----------------------------------------------------------------------------
package aetp_pkg;

	localparam int PARAM_SLOTS = 16;
	localparam int SLOT_W      = $clog2(PARAM_SLOTS);
	localparam int REPLY_MAX   = 10;
	localparam int REPLY_W     = $clog2(REPLY_MAX);

	localparam logic [7:0] ESC_BYTE      = 8'd27;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_BS         = 8'h08;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [3:0] FG_DEFAULT    = 4'd7;
	localparam logic [6:0] COLUMNS_RESET = 7'd80;
	localparam logic [5:0] ROWS_RESET    = 6'd24;

	localparam logic [1:0] CFG_COLUMNS      = 2'd0;
	localparam logic [1:0] CFG_ROWS         = 2'd1;
	localparam logic [1:0] CFG_COLOR_ENABLE = 2'd2;

	typedef enum logic [1:0] {
		STAGE_TEXT,
		STAGE_AFTER_ESC,
		STAGE_PARAMS
	} stage_t;

	typedef enum logic [2:0] {
		SUB_CLOSED,
		SUB_OPEN,
		SUB_FIVE,
		SUB_SIX,
		SUB_Y,
		SUB_X
	} sub_t;

	typedef enum logic [2:0] {
		KIND_UPDATE,
		KIND_CHAR,
		KIND_CLEAR,
		KIND_SCROLL,
		KIND_REPLY
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_UPD,
		OP_LFS,
		OP_PUT,
		OP_PUTS,
		OP_SPAN,
		OP_SCROLL,
		OP_SGR,
		OP_REPLY
	} op_t;

	typedef enum logic [1:0] {
		REP_Z,
		REP_FIVE,
		REP_DA,
		REP_CPR
	} rep_t;

	typedef enum logic [2:0] {
		SP_J0,
		SP_J1,
		SP_JALL,
		SP_K0,
		SP_K1,
		SP_K2
	} span_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WRAP,
		ST_EMIT,
		ST_PUT,
		ST_SPAN,
		ST_SCROLL,
		ST_SGR_RD,
		ST_SGR_EX,
		ST_REPLY
	} ctrl_state_t;

	typedef struct packed {
		logic  load;
		logic  decode;
		logic  emit;
		kind_t kind;
		logic  last;
		logic  sgr_read;
		logic  sgr_step;
		logic  rep_skip;
	} aetp_cmd_t;

	typedef struct packed {
		op_t  op;
		op_t  op_q;
		logic out_free;
		logic sgr_done;
		logic cnt_one;
		logic rep_keep;
		logic rep_last;
	} aetp_stat_t;

	// Decimal digits of a value below 256: hundreds, tens, ones.
	function automatic logic [11:0] dec3(input logic [7:0] v);
		logic [3:0]  h;
		logic [7:0]  r;
		logic [15:0] p;
		logic [3:0]  t;
		logic [7:0]  o;
		h = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
		r = v - 8'({4'd0, h} * 8'd100);
		p = {8'd0, r} * 16'd205;
		t = p[14:11];
		o = r - 8'({4'd0, t} * 8'd10);
		return {h, t, o[3:0]};
	endfunction

	// One-based parameter, clamped to 1..hi, to zero-based position 0..hi-1.
	function automatic logic [6:0] clamp1(input logic [15:0] v, input logic [6:0] hi);
		logic [15:0] t;
		t = (v == 16'd0) ? 16'd1 : v;
		if (t > {9'd0, hi}) begin
			t = {9'd0, hi};
		end
		return 7'(t - 16'd1);
	endfunction

endpackage

// ===== sv/ansi_escape_terminal_parser_top.sv =====
// ----------------------------------------------------------------------------
// ANSI terminal parser top level
// Parses a received byte stream into display commands and reply bytes.
// ----------------------------------------------------------------------------
// One byte request is taken at a time. A byte is accepted and then decoded,
// and each result it causes is emitted when the result register is free; an
// SGR sequence reads each parameter slot from the parameter memory before it
// is applied, and a reply skips each leading zero digit it leaves out. The
// input stall stays high until the last result of a byte has entered the
// result register, so a finished result may still wait downstream while the
// next byte is accepted.
module ansi_escape_terminal_parser_top import aetp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  kind,
	output logic [6:0]  col,
	output logic [5:0]  row,
	output logic [7:0]  char_code,
	output logic [12:0] span_start,
	output logic [12:0] span_count,
	output logic [3:0]  fg_index,
	output logic [3:0]  bg_index,
	output logic        last
);

	aetp_cmd_t  cmd;
	aetp_stat_t stat;

	aetp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	aetp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.stat       (stat),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.kind       (kind),
		.col        (col),
		.row        (row),
		.char_code  (char_code),
		.span_start (span_start),
		.span_count (span_count),
		.fg_index   (fg_index),
		.bg_index   (bg_index),
		.last       (last)
	);

endmodule

// ===== sv/aetp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Parser controller
// Sequences decode, result emission, SGR parameter walk and reply bytes.
// ----------------------------------------------------------------------------
module aetp_ctrl import aetp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  aetp_stat_t stat,
	output aetp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.kind = KIND_UPDATE;
		rx_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (rx_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				unique case (stat.op)
					OP_NONE:   state_d = ST_IDLE;
					OP_UPD:    state_d = ST_EMIT;
					OP_LFS:    state_d = ST_WRAP;
					OP_PUT:    state_d = ST_PUT;
					OP_PUTS:   state_d = ST_WRAP;
					OP_SPAN:   state_d = ST_SPAN;
					OP_SCROLL: state_d = ST_SCROLL;
					OP_SGR:    state_d = ST_SGR_RD;
					OP_REPLY:  state_d = ST_REPLY;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_WRAP: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_SCROLL;
					state_d  = (stat.op_q == OP_PUTS) ? ST_PUT : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_PUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_CHAR;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SPAN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_CLEAR;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SCROLL: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_SCROLL;
					cmd.last = stat.cnt_one;
					if (stat.cnt_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SGR_RD: begin
				cmd.sgr_read = 1'b1;
				state_d      = ST_SGR_EX;
			end
			ST_SGR_EX: begin
				cmd.sgr_step = 1'b1;
				state_d      = stat.sgr_done ? ST_EMIT : ST_SGR_RD;
			end
			ST_REPLY: begin
				if (!stat.rep_keep) begin
					cmd.rep_skip = 1'b1;
				end else if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_REPLY;
					cmd.last = stat.rep_last;
					if (stat.rep_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== sv/aetp_dp.sv =====
// ----------------------------------------------------------------------------
// Parser datapath
// Parser state, cursor, colors, parameter store and the result register.
// ----------------------------------------------------------------------------
module aetp_dp import aetp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic [7:0]  rx_byte,
	input  aetp_cmd_t   cmd,
	output aetp_stat_t  stat,
	input  logic        res_stall,
	output logic        res_valid,
	output logic [2:0]  kind,
	output logic [6:0]  col,
	output logic [5:0]  row,
	output logic [7:0]  char_code,
	output logic [12:0] span_start,
	output logic [12:0] span_count,
	output logic [3:0]  fg_index,
	output logic [3:0]  bg_index,
	output logic        last
);

	logic [6:0]  cols_q;
	logic [5:0]  rows_q;
	logic        color_en_q;
	stage_t      stage_q, nx_stage;
	sub_t        sub_q, nx_sub;
	logic [SLOT_W-1:0] count_q, nx_count;
	logic        closed_q, nx_closed;
	logic [15:0] acc_q, nx_acc;
	logic [15:0] p0_q, p1_q;
	logic        slot_wr;
	logic [15:0] param_mem [PARAM_SLOTS];
	logic [15:0] rd_q;
	logic [6:0]  cur_col_q, nx_col;
	logic [5:0]  cur_row_q, nx_row;
	logic [6:0]  sv_col_q;
	logic [5:0]  sv_row_q;
	logic        save_en;
	logic [3:0]  fg_q, bg_q;
	logic        bold_q;
	logic [7:0]  byte_q;
	op_t         op_q, op;
	logic [7:0]  char_q, put_ch;
	logic        put_en, restore_en;
	logic [12:0] line_q, total_q;
	span_t       span_q, nx_span;
	logic [5:0]  scnt_q, nx_scnt;
	logic [SLOT_W-1:0] idx_q;
	logic [7:0]  rbuf_q [REPLY_MAX];
	logic [7:0]  nx_rbuf [REPLY_MAX];
	logic [REPLY_MAX-1:0] rmask_q, nx_rmask;
	logic [REPLY_W-1:0]   ridx_q;
	logic        rep_en;
	rep_t        rep_sel;

	logic [6:0]  wcols;
	logic [5:0]  wrows;
	logic [7:0]  c;
	logic [7:0]  v;
	logic [15:0] a, n, p1;
	logic [6:0]  cc;
	logic [16:0] row_sum, col_sum;
	logic [7:0]  rp, cp;
	logic [11:0] rdig, cdig;
	logic [19:0] acc_prod;
	logic [12:0] lc;
	logic [12:0] sp_start, sp_count;
	logic [15:0] sgr_v;
	logic [15:0] d30, d40, d90, d100;
	logic        out_free;

	assign wcols = (cols_q == 7'd0) ? 7'd1 : cols_q;
	assign wrows = (rows_q == 6'd0) ? 6'd1 : rows_q;
	assign c     = byte_q;
	assign v     = (c >= CH_SPACE) ? (c - CH_SPACE) : 8'd0;
	assign a     = (count_q == '0) ? acc_q : p0_q;
	assign n     = (a == 16'd0) ? 16'd1 : a;
	assign p1    = (count_q == '0) ? 16'd0 : ((count_q == SLOT_W'(1)) ? acc_q : p1_q);
	assign cc    = (cur_col_q < wcols) ? cur_col_q : (wcols - 7'd1);
	assign row_sum = {11'd0, cur_row_q} + {1'b0, n};
	assign col_sum = {10'd0, cur_col_q} + {1'b0, n};
	assign rp    = {2'd0, cur_row_q} + 8'd1;
	assign cp    = {1'b0, cc} + 8'd1;
	assign rdig  = dec3(rp);
	assign cdig  = dec3(cp);
	assign acc_prod = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'd0, c[3:0]};

	assign out_free = !res_valid || !res_stall;

	always_comb begin
		stat          = '0;
		stat.op       = op;
		stat.op_q     = op_q;
		stat.out_free = out_free;
		stat.sgr_done = (idx_q == count_q);
		stat.cnt_one  = (scnt_q == 6'd1);
		stat.rep_keep = rmask_q[ridx_q];
		stat.rep_last = ((rmask_q >> ridx_q) == REPLY_MAX'(1));
	end

	// Byte decode: next parser state, cursor move and the kind of work that follows.
	always_comb begin
		nx_stage   = stage_q;
		nx_sub     = sub_q;
		nx_col     = cur_col_q;
		nx_row     = cur_row_q;
		nx_count   = count_q;
		nx_closed  = closed_q;
		nx_acc     = acc_q;
		nx_span    = span_q;
		nx_scnt    = scnt_q;
		slot_wr    = 1'b0;
		save_en    = 1'b0;
		restore_en = 1'b0;
		put_en     = 1'b0;
		put_ch     = c;
		rep_en     = 1'b0;
		rep_sel    = REP_Z;
		op         = OP_NONE;
		unique case (stage_q)
			STAGE_AFTER_ESC: begin
				if (sub_q == SUB_OPEN) begin
					nx_stage = STAGE_TEXT;
					nx_sub   = SUB_CLOSED;
					priority case (c)
						"[": begin
							nx_stage  = STAGE_PARAMS;
							nx_count  = '0;
							nx_acc    = 16'd0;
							nx_closed = 1'b0;
						end
						"7": save_en = 1'b1;
						"8": restore_en = 1'b1;
						"5": begin
							nx_stage = STAGE_AFTER_ESC;
							nx_sub   = SUB_FIVE;
						end
						"6": begin
							nx_stage = STAGE_AFTER_ESC;
							nx_sub   = SUB_SIX;
						end
						"Y": begin
							nx_stage = STAGE_AFTER_ESC;
							nx_sub   = SUB_Y;
						end
						"Z": begin
							rep_en  = 1'b1;
							rep_sel = REP_Z;
						end
						default: ;
					endcase
				end else if (sub_q == SUB_Y) begin
					nx_row = ({2'd0, wrows} > v) ? v[5:0] : (wrows - 6'd1);
					nx_sub = SUB_X;
					op     = OP_UPD;
				end else if (sub_q == SUB_X) begin
					nx_col   = ({1'b0, wcols} > v) ? v[6:0] : (wcols - 7'd1);
					nx_stage = STAGE_TEXT;
					nx_sub   = SUB_CLOSED;
					op       = OP_UPD;
				end else begin
					if (c == "n" && sub_q == SUB_FIVE) begin
						rep_en  = 1'b1;
						rep_sel = REP_FIVE;
					end else if (c == "n" && sub_q == SUB_SIX) begin
						rep_en  = 1'b1;
						rep_sel = REP_CPR;
					end
					nx_stage = STAGE_TEXT;
					nx_sub   = SUB_CLOSED;
				end
			end
			STAGE_PARAMS: begin
				if (c >= 8'h40 && c <= 8'h7E) begin
					nx_stage = STAGE_TEXT;
					priority case (c)
						"A", "F": begin
							nx_row = (n >= {10'd0, cur_row_q}) ? 6'd0 : (cur_row_q - n[5:0]);
							if (c == "F") begin
								nx_col = 7'd0;
							end
							op = OP_UPD;
						end
						"B", "E": begin
							nx_row = (row_sum >= {11'd0, wrows}) ? (wrows - 6'd1) : row_sum[5:0];
							if (c == "E") begin
								nx_col = 7'd0;
							end
							op = OP_UPD;
						end
						"C": begin
							nx_col = (col_sum >= {10'd0, wcols}) ? (wcols - 7'd1) : col_sum[6:0];
							op = OP_UPD;
						end
						"D": begin
							nx_col = (n >= {9'd0, cur_col_q}) ? 7'd0 : (cur_col_q - n[6:0]);
							op = OP_UPD;
						end
						"G": begin
							nx_col = clamp1(a, wcols);
							op = OP_UPD;
						end
						"H", "f": begin
							nx_row = 6'(clamp1(a, {1'b0, wrows}));
							nx_col = clamp1(p1, wcols);
							op = OP_UPD;
						end
						"J": begin
							if (a == 16'd0) begin
								nx_span = SP_J0;
								op      = OP_SPAN;
							end else if (a == 16'd1) begin
								nx_span = SP_J1;
								op      = OP_SPAN;
							end else if (a == 16'd2 || a == 16'd3) begin
								nx_span = SP_JALL;
								nx_col  = 7'd0;
								nx_row  = 6'd0;
								op      = OP_SPAN;
							end
						end
						"K": begin
							if (a == 16'd0) begin
								nx_span = SP_K0;
								op      = OP_SPAN;
							end else if (a == 16'd1) begin
								nx_span = SP_K1;
								op      = OP_SPAN;
							end else if (a == 16'd2) begin
								nx_span = SP_K2;
								op      = OP_SPAN;
							end
						end
						"S": begin
							nx_scnt = (n > {10'd0, wrows}) ? wrows : n[5:0];
							nx_col  = 7'd0;
							nx_row  = wrows - 6'd1;
							op      = OP_SCROLL;
						end
						"T": begin
							put_en = 1'b1;
							put_ch = "^";
						end
						"m": begin
							if (color_en_q) begin
								op = OP_SGR;
							end
						end
						"n": begin
							if (a == 16'd6) begin
								rep_en  = 1'b1;
								rep_sel = REP_CPR;
							end
						end
						"s": save_en = 1'b1;
						"u": restore_en = 1'b1;
						"c": begin
							rep_en  = 1'b1;
							rep_sel = REP_DA;
						end
						default: ;
					endcase
				end else if (c >= CH_ZERO && c <= 8'h3F) begin
					if (c <= "9") begin
						if (!closed_q) begin
							nx_acc = (acc_prod > 20'hFFFF) ? 16'hFFFF : acc_prod[15:0];
						end
					end else if (c == ";") begin
						if ({1'b0, count_q} + 1'b1 < (SLOT_W + 1)'(PARAM_SLOTS)) begin
							slot_wr  = 1'b1;
							nx_count = count_q + 1'b1;
							nx_acc   = 16'd0;
						end else begin
							nx_closed = 1'b1;
						end
					end
				end else begin
					nx_stage = STAGE_TEXT;
				end
			end
			default: begin
				nx_stage = STAGE_TEXT;
				if (c == ESC_BYTE) begin
					nx_stage = STAGE_AFTER_ESC;
					nx_sub   = SUB_OPEN;
				end else if (c == CH_CR) begin
					nx_col = 7'd0;
					op     = OP_UPD;
				end else if (c == CH_LF) begin
					nx_col = 7'd0;
					if ({1'b0, cur_row_q} + 7'd1 < {1'b0, wrows}) begin
						nx_row = cur_row_q + 6'd1;
						op     = OP_UPD;
					end else begin
						op = OP_LFS;
					end
				end else if (c == CH_BS) begin
					if (cur_col_q == 7'd0) begin
						nx_col = wcols - 7'd1;
						if (cur_row_q != 6'd0) begin
							nx_row = cur_row_q - 6'd1;
						end
					end else begin
						nx_col = cur_col_q - 7'd1;
					end
					op = OP_UPD;
				end else if (c >= CH_SPACE) begin
					put_en = 1'b1;
				end
			end
		endcase

		if (put_en) begin
			op = OP_PUT;
			if (cur_col_q >= wcols) begin
				nx_col = 7'd0;
				if ({1'b0, cur_row_q} + 7'd1 < {1'b0, wrows}) begin
					nx_row = cur_row_q + 6'd1;
				end else begin
					op = OP_PUTS;
				end
			end
		end
		if (restore_en) begin
			nx_col = (sv_col_q < wcols) ? sv_col_q : (wcols - 7'd1);
			nx_row = (sv_row_q < wrows) ? sv_row_q : (wrows - 6'd1);
			op     = OP_UPD;
		end
		if (rep_en) begin
			op = OP_REPLY;
		end
	end

	// Reply bytes sit at fixed places; the mask leaves out leading zero digits.
	always_comb begin
		for (int i = 0; i < REPLY_MAX; i++) begin
			nx_rbuf[i] = 8'd0;
		end
		nx_rbuf[0] = ESC_BYTE;
		nx_rmask   = '0;
		unique case (rep_sel)
			REP_Z: begin
				nx_rbuf[1] = "/";
				nx_rbuf[2] = "Z";
				nx_rmask   = REPLY_MAX'(10'b0000000111);
			end
			REP_FIVE: begin
				nx_rbuf[1] = "0";
				nx_rbuf[2] = "n";
				nx_rmask   = REPLY_MAX'(10'b0000000111);
			end
			REP_DA: begin
				nx_rbuf[1] = "[";
				nx_rbuf[2] = "?";
				nx_rbuf[3] = "1";
				nx_rbuf[4] = ";";
				nx_rbuf[5] = "0";
				nx_rbuf[6] = "c";
				nx_rmask   = REPLY_MAX'(10'b0001111111);
			end
			REP_CPR: begin
				nx_rbuf[1] = "[";
				nx_rbuf[2] = CH_ZERO + {4'd0, rdig[11:8]};
				nx_rbuf[3] = CH_ZERO + {4'd0, rdig[7:4]};
				nx_rbuf[4] = CH_ZERO + {4'd0, rdig[3:0]};
				nx_rbuf[5] = ";";
				nx_rbuf[6] = CH_ZERO + {4'd0, cdig[11:8]};
				nx_rbuf[7] = CH_ZERO + {4'd0, cdig[7:4]};
				nx_rbuf[8] = CH_ZERO + {4'd0, cdig[3:0]};
				nx_rbuf[9] = "R";
				nx_rmask   = {1'b1, 1'b1, cp >= 8'd10, cp >= 8'd100, 1'b1,
					1'b1, rp >= 8'd10, rp >= 8'd100, 1'b1, 1'b1};
			end
			default: ;
		endcase
	end

	assign lc = line_q + {6'd0, cc};

	always_comb begin
		sp_start = 13'd0;
		sp_count = 13'd0;
		unique case (span_q)
			SP_J0: begin
				sp_start = lc;
				sp_count = total_q - lc;
			end
			SP_J1:   sp_count = lc + 13'd1;
			SP_JALL: sp_count = total_q;
			SP_K0: begin
				sp_start = lc;
				sp_count = {6'd0, wcols - cc};
			end
			SP_K1: begin
				sp_start = line_q;
				sp_count = {6'd0, cc} + 13'd1;
			end
			SP_K2: begin
				sp_start = line_q;
				sp_count = {6'd0, wcols};
			end
			default: ;
		endcase
	end

	assign sgr_v = (idx_q == count_q) ? acc_q : rd_q;
	assign d30   = sgr_v - 16'd30;
	assign d40   = sgr_v - 16'd40;
	assign d90   = sgr_v - 16'd90;
	assign d100  = sgr_v - 16'd100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q     <= COLUMNS_RESET;
			rows_q     <= ROWS_RESET;
			color_en_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_COLUMNS) begin
				cols_q <= cfg_data;
			end else if (cfg_index == CFG_ROWS) begin
				rows_q <= cfg_data[5:0];
			end else if (cfg_index == CFG_COLOR_ENABLE) begin
				color_en_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= STAGE_TEXT;
			sub_q     <= SUB_CLOSED;
			count_q   <= '0;
			closed_q  <= 1'b0;
			cur_col_q <= 7'd0;
			cur_row_q <= 6'd0;
			sv_col_q  <= 7'd0;
			sv_row_q  <= 6'd0;
			fg_q      <= FG_DEFAULT;
			bg_q      <= 4'd0;
			bold_q    <= 1'b0;
			op_q      <= OP_NONE;
			scnt_q    <= 6'd0;
			idx_q     <= '0;
			ridx_q    <= '0;
			rmask_q   <= '0;
		end else begin
			if (cmd.load) begin
				// A cursor off a narrowed screen is clamped; column to the width.
				if (cur_col_q > wcols) begin
					cur_col_q <= wcols;
				end
				if (cur_row_q >= wrows) begin
					cur_row_q <= wrows - 6'd1;
				end
			end
			if (cmd.decode) begin
				stage_q   <= nx_stage;
				sub_q     <= nx_sub;
				count_q   <= nx_count;
				closed_q  <= nx_closed;
				cur_col_q <= nx_col;
				cur_row_q <= nx_row;
				op_q      <= op;
				scnt_q    <= nx_scnt;
				idx_q     <= '0;
				ridx_q    <= '0;
				rmask_q   <= nx_rmask;
				if (save_en) begin
					sv_col_q <= cur_col_q;
					sv_row_q <= cur_row_q;
				end
			end
			if (cmd.sgr_step) begin
				idx_q <= idx_q + 1'b1;
				if (sgr_v == 16'd0) begin
					bold_q <= 1'b0;
					fg_q   <= FG_DEFAULT;
					bg_q   <= 4'd0;
				end else if (sgr_v == 16'd1) begin
					bold_q <= 1'b1;
				end else if (sgr_v >= 16'd30 && sgr_v <= 16'd37) begin
					fg_q <= {1'b0, d30[2:0]};
				end else if (sgr_v >= 16'd40 && sgr_v <= 16'd47) begin
					bg_q <= {1'b0, d40[2:0]};
				end else if (sgr_v >= 16'd90 && sgr_v <= 16'd97) begin
					fg_q <= {1'b1, d90[2:0]};
				end else if (sgr_v >= 16'd100 && sgr_v <= 16'd107) begin
					bg_q <= {1'b1, d100[2:0]};
				end
			end
			if (cmd.rep_skip) begin
				ridx_q <= ridx_q + 1'b1;
			end
			if (cmd.emit) begin
				if (cmd.kind == KIND_CHAR) begin
					cur_col_q <= cur_col_q + 7'd1;
				end
				if (cmd.kind == KIND_SCROLL && op_q == OP_SCROLL) begin
					scnt_q <= scnt_q - 6'd1;
				end
				if (cmd.kind == KIND_REPLY) begin
					ridx_q <= ridx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= rx_byte;
		end
		if (cmd.decode) begin
			acc_q   <= nx_acc;
			char_q  <= put_ch;
			span_q  <= nx_span;
			line_q  <= {7'd0, cur_row_q} * {6'd0, wcols};
			total_q <= {7'd0, wrows} * {6'd0, wcols};
			if (slot_wr) begin
				param_mem[count_q] <= acc_q;
				if (count_q == '0) begin
					p0_q <= acc_q;
				end
				if (count_q == SLOT_W'(1)) begin
					p1_q <= acc_q;
				end
			end
			if (rep_en) begin
				for (int i = 0; i < REPLY_MAX; i++) begin
					rbuf_q[i] <= nx_rbuf[i];
				end
			end
		end
		if (cmd.sgr_read) begin
			rd_q <= param_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.emit) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind       <= cmd.kind;
			col        <= cur_col_q;
			row        <= cur_row_q;
			char_code  <= (cmd.kind == KIND_CHAR) ? char_q :
				((cmd.kind == KIND_REPLY) ? rbuf_q[ridx_q] : 8'd0);
			span_start <= (cmd.kind == KIND_CLEAR) ? sp_start : 13'd0;
			span_count <= (cmd.kind == KIND_CLEAR) ? sp_count : 13'd0;
			fg_index   <= fg_q | {bold_q, 3'b000};
			bg_index   <= bg_q;
			last       <= cmd.last;
		end
	end

endmodule
